### src/cctun_pkg.sv
// Shared package of the Cohen-Coon tuner: fixed-point constants, widths,
// request and result types and the saturation helper.
// Depends on nothing; every other file imports it.
`default_nettype none

package cctun_pkg;

    localparam int FRAC_BITS = 16;
    localparam longint ONE_L = longint'(1) << FRAC_BITS;
    localparam logic [63:0] ONE = 64'(ONE_L);

    // Constants rounded to nearest, halves up.
    localparam logic [63:0] C_135 = 64'((135 * ONE_L + 50) / 100);
    localparam logic [63:0] C_027 = 64'((27 * ONE_L + 50) / 100);
    localparam logic [63:0] C_25  = 64'((25 * ONE_L + 5) / 10);
    localparam logic [63:0] C_05  = 64'((5 * ONE_L + 5) / 10);
    localparam logic [63:0] C_037 = 64'((37 * ONE_L + 50) / 100);
    localparam logic [63:0] C_02  = 64'((2 * ONE_L + 5) / 10);
    localparam logic [63:0] C_06  = 64'((6 * ONE_L + 5) / 10);
    localparam logic [63:0] C_08  = 64'((8 * ONE_L + 5) / 10);
    localparam logic [63:0] C_12  = 64'((12 * ONE_L + 5) / 10);
    localparam logic [63:0] C_20  = 64'(20 * ONE_L);
    localparam logic [63:0] C_30  = 64'(30 * ONE_L);
    localparam logic [63:0] C_5   = 64'(5 * ONE_L);

    localparam logic signed [31:0] OS_FLOOR = 32'(C_5);
    localparam logic signed [31:0] S32_MAX  = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] S32_MIN  = 32'sh8000_0000;
    localparam logic [30:0]        RATIO_MAX = 31'h7FFF_FFFF;

    // Restoring divider: 64-bit dividend, 32 quotient bits, wide divisor.
    localparam int DIV_NW  = 64;
    localparam int DIV_QW  = 32;
    localparam int DIV_DW  = 63 - FRAC_BITS;
    localparam int DIV_LAT = DIV_QW + 1;

    localparam int R2_W  = 62 - FRAC_BITS;
    localparam int CF_W  = FRAC_BITS + 1;
    localparam int F1_W  = FRAC_BITS + 2;
    localparam int P_W   = FRAC_BITS + 2;
    localparam int OST_W = 36;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Correction classes.
    localparam logic [1:0] CLS_UNITY = 2'd0;
    localparam logic [1:0] CLS_LOW   = 2'd1;
    localparam logic [1:0] CLS_HIGH  = 2'd2;

    typedef struct packed {
        logic signed [31:0] process_gain;
        logic signed [31:0] time_constant;
        logic signed [31:0] dead_time;
    } in_t;

    typedef struct packed {
        logic               valid_res;
        logic               overflow;
        logic signed [31:0] prop_gain;
        logic signed [31:0] integral_time;
        logic signed [31:0] derivative_time;
        logic signed [31:0] integral_gain;
        logic signed [31:0] derivative_gain;
        logic signed [31:0] expected_overshoot;
        logic signed [31:0] settling_time;
        logic [30:0]        delay_ratio;
        logic [1:0]         correction_class;
    } out_t;

    // Classified request as it waits in the queue.
    typedef struct packed {
        logic               model_ok;
        logic               k_zero;
        logic               k_neg;
        logic [31:0]        k_abs;
        logic signed [31:0] t;
        logic signed [31:0] l;
    } qitem_t;

    typedef struct packed {
        logic               sat;
        logic signed [31:0] val;
    } sres_t;

    // Signed 32-bit value from a quotient magnitude, its too-large flag and sign.
    function automatic sres_t sat_div(input logic [31:0] q, input logic big,
                                      input logic neg);
        sres_t res;
        if (neg) begin
            if (big || q > 32'h8000_0000) begin
                res.sat = 1'b1;
                res.val = S32_MIN;
            end else begin
                res.sat = 1'b0;
                res.val = $signed(32'(-q));
            end
        end else begin
            if (big || q[31]) begin
                res.sat = 1'b1;
                res.val = S32_MAX;
            end else begin
                res.sat = 1'b0;
                res.val = $signed(q);
            end
        end
        return res;
    endfunction

endpackage

`default_nettype wire

### src/cctun_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Depends on cctun_pkg for its widths.
`default_nettype none

module cctun_div import cctun_pkg::*; (
    input  logic              aclk,
    input  logic              en,
    input  logic [DIV_NW-1:0] num,
    input  logic [DIV_DW-1:0] den,
    output logic [DIV_QW-1:0] quo,
    output logic              big
);

    logic [DIV_DW-1:0] rem_reg [0:DIV_QW];
    logic [DIV_QW-1:0] quo_reg [0:DIV_QW];
    logic              big_reg [0:DIV_QW];
    logic [DIV_QW-1:0] low_reg [0:DIV_QW-1];
    logic [DIV_DW-1:0] den_reg [0:DIV_QW-1];

    logic [DIV_DW:0]   shift_val [0:DIV_QW-1];
    logic              fits      [0:DIV_QW-1];
    logic [DIV_DW-1:0] rem_next  [0:DIV_QW-1];

    always_comb begin
        for (int i = 0; i < DIV_QW; i++) begin
            shift_val[i] = {rem_reg[i], low_reg[i][DIV_QW-1-i]};
            fits[i]      = shift_val[i] >= {1'b0, den_reg[i]};
            rem_next[i]  = fits[i] ? DIV_DW'(shift_val[i] - {1'b0, den_reg[i]})
                                   : shift_val[i][DIV_DW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            // The upper half must be below the divisor for a 32-bit quotient.
            rem_reg[0] <= DIV_DW'(num[DIV_NW-1:DIV_QW]);
            low_reg[0] <= num[DIV_QW-1:0];
            den_reg[0] <= den;
            quo_reg[0] <= '0;
            big_reg[0] <= DIV_DW'(num[DIV_NW-1:DIV_QW]) >= den;
            for (int i = 0; i < DIV_QW; i++) begin
                rem_reg[i+1] <= rem_next[i];
                quo_reg[i+1] <= {quo_reg[i][DIV_QW-2:0], fits[i]};
                big_reg[i+1] <= big_reg[i];
            end
            for (int i = 0; i < DIV_QW - 1; i++) begin
                low_reg[i+1] <= low_reg[i];
                den_reg[i+1] <= den_reg[i];
            end
        end
    end

    assign quo = quo_reg[DIV_QW];
    assign big = big_reg[DIV_QW];

endmodule

`default_nettype wire

### src/cctun_front.sv
// Front end: takes requests and classifies the process model.
// Depends on cctun_pkg.
`default_nettype none

module cctun_front import cctun_pkg::*; (
    input  logic   s_valid,
    output logic   s_ready,
    input  in_t    s_data,
    input  logic   q_full,
    output logic   q_push,
    output qitem_t q_item
);

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    always_comb begin
        q_item.model_ok = (s_data.time_constant > 32'sd0) && !s_data.dead_time[31];
        q_item.k_zero   = s_data.process_gain == 32'sd0;
        q_item.k_neg    = s_data.process_gain[31];
        q_item.k_abs    = s_data.process_gain[31] ? 32'(-s_data.process_gain)
                                                  : 32'(s_data.process_gain);
        q_item.t        = s_data.time_constant;
        q_item.l        = s_data.dead_time;
    end

endmodule

`default_nettype wire

### src/cctun_queue.sv
// Short queue between the front end and the arithmetic back end.
// Depends on cctun_pkg.
`default_nettype none

module cctun_queue import cctun_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   push,
    input  qitem_t push_item,
    output logic   full,
    input  logic   pop,
    output logic   not_empty,
    output qitem_t head_item
);

    qitem_t              entry_reg [0:QUEUE_DEPTH-1];
    logic [QUEUE_AW-1:0] wr_ptr_reg;
    logic [QUEUE_AW-1:0] rd_ptr_reg;
    logic [QUEUE_CW-1:0] count_reg;
    logic [QUEUE_CW-1:0] count_next;
    logic                do_pop;

    assign full      = count_reg == QUEUE_CW'(QUEUE_DEPTH);
    assign not_empty = count_reg != '0;
    assign head_item = entry_reg[rd_ptr_reg];
    assign do_pop    = pop && not_empty;

    always_comb begin
        count_next = count_reg;
        if (push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

### src/cctun_back.sv
// Back end: the arithmetic pipeline, four divider passes and the output register.
// Depends on cctun_pkg and cctun_div.
`default_nettype none

module cctun_back import cctun_pkg::*; (
    input  logic   aclk,
    input  logic   aresetn,
    input  logic   q_valid,
    input  qitem_t q_item,
    output logic   q_pop,
    output logic   m_valid,
    input  logic   m_ready,
    output out_t   m_data
);

    typedef struct packed {
        logic               model_ok;
        logic               k_zero;
        logic               k_neg;
        logic [31:0]        k_abs;
        logic signed [31:0] t;
        logic signed [31:0] l;
        logic               ov;
        logic [30:0]        r;
        logic [1:0]         cls;
        logic [CF_W-1:0]    cf;
        logic [R2_W-1:0]    r2;
        logic [30:0]        num1;
        logic [30:0]        half_r;
        logic [30:0]        dterm;
        logic [OST_W-1:0]   osterm;
        logic [DIV_DW-1:0]  den1;
        logic [31:0]        tden;
        logic [31:0]        dden;
        logic               tneg;
        logic [63:0]        tmag;
        logic [63:0]        tdprod;
        logic signed [31:0] os;
        logic signed [31:0] st;
        logic signed [31:0] ti;
        logic signed [31:0] td;
        logic [F1_W-1:0]    f1;
        logic [P_W-1:0]     p;
        logic signed [31:0] kp;
        logic signed [63:0] kdprod;
    } ctx_t;

    localparam int F = FRAC_BITS;
    localparam logic signed [63:0] S64_MAX = 64'(S32_MAX);
    localparam logic signed [63:0] S64_MIN = 64'(S32_MIN);

    logic en;

    // Stage registers and the delay lines that run beside each divider.
    ctx_t c0_reg, c1_reg, c2_reg, c3_reg, c4_reg, c5_reg, c6_reg, c7_reg;
    ctx_t c0_next, c1_next, c2_next, c3_next, c4_next, c5_next, c6_next, c7_next;
    ctx_t ca_reg [0:DIV_LAT-1];
    ctx_t cb_reg [0:DIV_LAT-1];
    ctx_t cc_reg [0:DIV_LAT-1];
    ctx_t cd_reg [0:DIV_LAT-1];
    ctx_t ca_next, cd_next;
    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, vout_reg;
    logic [DIV_LAT-1:0] va_reg, vb_reg, vc_reg, vd_reg;
    out_t out_reg, out_next;

    logic [DIV_QW-1:0] qa, qb1, qb2, qb3, qc, qd;
    logic              biga, bigb1, bigb2, bigb3, bigc, bigd;
    logic [31:0]       kp_abs, ti_abs;

    assign en      = !vout_reg || m_ready;
    assign q_pop   = en && q_valid;
    assign m_valid = vout_reg;
    assign m_data  = out_reg;

    // Queue head into the pipeline.
    always_comb begin
        c0_next          = '0;
        c0_next.model_ok = q_item.model_ok;
        c0_next.k_zero   = q_item.k_zero;
        c0_next.k_neg    = q_item.k_neg;
        c0_next.k_abs    = q_item.k_abs;
        c0_next.t        = q_item.t;
        c0_next.l        = q_item.l;
    end

    // Settling time, beside the ratio division.
    always_comb begin
        logic [32:0] sum;
        logic [34:0] st3;
        sum     = {1'b0, c0_reg.l} + {1'b0, c0_reg.t};
        st3     = {2'b00, sum} + {1'b0, sum, 1'b0};
        ca_next = c0_reg;
        if (st3 > 35'(S32_MAX)) begin
            ca_next.st = S32_MAX;
            ca_next.ov = 1'b1;
        end else begin
            ca_next.st = $signed(st3[31:0]);
        end
    end

    cctun_div u_div_ratio (
        .aclk (aclk),
        .en   (en),
        .num  (64'($unsigned(c0_reg.l)) << F),
        .den  (DIV_DW'($unsigned(c0_reg.t))),
        .quo  (qa),
        .big  (biga)
    );

    // Ratio saturation and correction class.
    always_comb begin
        logic rsat;
        c1_next = ca_reg[DIV_LAT-1];
        rsat    = biga || qa[31];
        c1_next.r  = rsat ? RATIO_MAX : qa[30:0];
        c1_next.ov = c1_next.ov || rsat;
        if (64'(c1_next.r) > C_06) begin
            c1_next.cls = CLS_LOW;
            c1_next.cf  = CF_W'(C_08);
        end else if (64'(c1_next.r) < C_02) begin
            c1_next.cls = CLS_HIGH;
            c1_next.cf  = CF_W'(C_12);
        end else begin
            c1_next.cls = CLS_UNITY;
            c1_next.cf  = CF_W'(ONE);
        end
    end

    // Products of the ratio.
    always_comb begin
        c2_next        = c1_reg;
        c2_next.r2     = R2_W'((64'(c1_reg.r) * 64'(c1_reg.r)) >> F);
        c2_next.num1   = 31'((64'(c1_reg.r) * C_027) >> F);
        c2_next.half_r = 31'((64'(c1_reg.r) * C_05) >> F);
        c2_next.dterm  = 31'((64'(c1_reg.r) * C_02) >> F);
        c2_next.osterm = OST_W'((64'(c1_reg.r) * C_30) >> F);
    end

    // Denominators and dividends of the three parallel divisions.
    always_comb begin
        logic signed [32:0] tnum;
        logic signed [63:0] tprod;
        c3_next      = c2_reg;
        c3_next.den1 = DIV_DW'(ONE + ((64'(c2_reg.r2) * C_027) >> F));
        tnum         = $signed(33'(C_25) - {2'b00, c2_reg.half_r});
        tprod        = 64'(c2_reg.t) * 64'(tnum);
        c3_next.tneg = tprod[63];
        c3_next.tmag = tprod[63] ? 64'(-tprod) : 64'(tprod);
        c3_next.tden = ONE[31:0] + {1'b0, c2_reg.half_r};
        c3_next.dden = ONE[31:0] + {1'b0, c2_reg.dterm};
        c3_next.tdprod = 64'($unsigned(c2_reg.t)) * C_037;
        // Overshoot falls with the ratio down to a floor of five percent.
        if (c2_reg.osterm > OST_W'(C_20 - C_5)) begin
            c3_next.os = OS_FLOOR;
        end else begin
            c3_next.os = $signed(32'(C_20 - 64'(c2_reg.osterm)));
        end
    end

    cctun_div u_div_f1 (
        .aclk (aclk),
        .en   (en),
        .num  (64'(c3_reg.num1) << F),
        .den  (c3_reg.den1),
        .quo  (qb1),
        .big  (bigb1)
    );

    cctun_div u_div_ti (
        .aclk (aclk),
        .en   (en),
        .num  (c3_reg.tmag),
        .den  (DIV_DW'(c3_reg.tden)),
        .quo  (qb2),
        .big  (bigb2)
    );

    cctun_div u_div_td (
        .aclk (aclk),
        .en   (en),
        .num  (c3_reg.tdprod),
        .den  (DIV_DW'(c3_reg.dden)),
        .quo  (qb3),
        .big  (bigb3)
    );

    always_comb begin
        sres_t rti, rtd;
        c4_next    = cb_reg[DIV_LAT-1];
        // The gain-shaping quotient stays well below one.
        c4_next.f1 = F1_W'(ONE) + F1_W'(qb1);
        rti        = sat_div(qb2, bigb2, c4_next.tneg);
        rtd        = sat_div(qb3, bigb3, 1'b0);
        c4_next.ti = rti.val;
        c4_next.td = rtd.val;
        c4_next.ov = c4_next.ov || rti.sat || rtd.sat;
    end

    always_comb begin
        c5_next   = c4_reg;
        c5_next.p = P_W'((C_135 * 64'(c4_reg.f1)) >> F);
    end

    always_comb begin
        c6_next   = c5_reg;
        c6_next.p = P_W'((64'(c5_reg.p) * 64'(c5_reg.cf)) >> F);
    end

    cctun_div u_div_kp (
        .aclk (aclk),
        .en   (en),
        .num  (64'(c6_reg.p) << F),
        .den  (DIV_DW'(c6_reg.k_abs)),
        .quo  (qc),
        .big  (bigc)
    );

    always_comb begin
        sres_t rkp;
        c7_next = cc_reg[DIV_LAT-1];
        rkp     = sat_div(qc, bigc, c7_next.k_neg);
        if (c7_next.k_zero) begin
            c7_next.kp = S32_MAX;
            c7_next.ov = 1'b1;
        end else begin
            c7_next.kp = rkp.val;
            c7_next.ov = c7_next.ov || rkp.sat;
        end
    end

    assign kp_abs = c7_reg.kp[31] ? 32'(-c7_reg.kp) : 32'(c7_reg.kp);
    assign ti_abs = c7_reg.ti[31] ? 32'(-c7_reg.ti) : 32'(c7_reg.ti);

    always_comb begin
        cd_next        = c7_reg;
        cd_next.kdprod = 64'(c7_reg.kp) * 64'(c7_reg.td);
    end

    cctun_div u_div_ki (
        .aclk (aclk),
        .en   (en),
        .num  (64'(kp_abs) << F),
        .den  (DIV_DW'(ti_abs)),
        .quo  (qd),
        .big  (bigd)
    );

    // Final gains, saturation and the result word.
    always_comb begin
        ctx_t               c;
        sres_t              rki;
        logic signed [63:0] kd_bias;
        logic signed [63:0] kdq;
        logic signed [31:0] ki;
        logic signed [31:0] kd;
        logic               ov;
        c       = cd_reg[DIV_LAT-1];
        ov      = c.ov;
        rki     = sat_div(qd, bigd, c.kp[31] ^ c.ti[31]);
        if (c.ti == 32'sd0) begin
            ki = c.kp[31] ? S32_MIN : S32_MAX;
            ov = 1'b1;
        end else begin
            ki = rki.val;
            ov = ov || rki.sat;
        end
        // Truncate the product toward zero before dropping the fraction bits.
        kd_bias = c.kdprod + $signed(ONE - 64'd1);
        kdq     = (c.kdprod[63] ? kd_bias : c.kdprod) >>> F;
        if (kdq > S64_MAX) begin
            kd = S32_MAX;
            ov = 1'b1;
        end else if (kdq < S64_MIN) begin
            kd = S32_MIN;
            ov = 1'b1;
        end else begin
            kd = 32'(kdq);
        end
        out_next = '0;
        if (c.model_ok) begin
            out_next.valid_res          = !c.k_zero;
            out_next.overflow           = ov;
            out_next.prop_gain          = c.kp;
            out_next.integral_time      = c.ti;
            out_next.derivative_time    = c.td;
            out_next.integral_gain      = ki;
            out_next.derivative_gain    = kd;
            out_next.expected_overshoot = c.os;
            out_next.settling_time      = c.st;
            out_next.delay_ratio        = c.r;
            out_next.correction_class   = c.cls;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg   <= 1'b0;
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            v4_reg   <= 1'b0;
            v5_reg   <= 1'b0;
            v6_reg   <= 1'b0;
            v7_reg   <= 1'b0;
            vout_reg <= 1'b0;
            va_reg   <= '0;
            vb_reg   <= '0;
            vc_reg   <= '0;
            vd_reg   <= '0;
        end else if (en) begin
            v0_reg   <= q_valid;
            va_reg   <= {va_reg[DIV_LAT-2:0], v0_reg};
            v1_reg   <= va_reg[DIV_LAT-1];
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            vb_reg   <= {vb_reg[DIV_LAT-2:0], v3_reg};
            v4_reg   <= vb_reg[DIV_LAT-1];
            v5_reg   <= v4_reg;
            v6_reg   <= v5_reg;
            vc_reg   <= {vc_reg[DIV_LAT-2:0], v6_reg};
            v7_reg   <= vc_reg[DIV_LAT-1];
            vd_reg   <= {vd_reg[DIV_LAT-2:0], v7_reg};
            vout_reg <= vd_reg[DIV_LAT-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c0_reg    <= c0_next;
            ca_reg[0] <= ca_next;
            c1_reg    <= c1_next;
            c2_reg    <= c2_next;
            c3_reg    <= c3_next;
            cb_reg[0] <= c3_reg;
            c4_reg    <= c4_next;
            c5_reg    <= c5_next;
            c6_reg    <= c6_next;
            cc_reg[0] <= c6_reg;
            c7_reg    <= c7_next;
            cd_reg[0] <= cd_next;
            out_reg   <= out_next;
            for (int i = 1; i < DIV_LAT; i++) begin
                ca_reg[i] <= ca_reg[i-1];
                cb_reg[i] <= cb_reg[i-1];
                cc_reg[i] <= cc_reg[i-1];
                cd_reg[i] <= cd_reg[i-1];
            end
        end
    end

endmodule

`default_nettype wire

### src/cohen_coon_pid_tuner.sv
// Top level of the Cohen-Coon PID tuner: front end, queue and arithmetic back end.
// Depends on cctun_pkg, cctun_front, cctun_queue and cctun_back.
`default_nettype none

//  Channel  | Ports                      | Direction | Carries
//  ---------+----------------------------+-----------+------------------------------
//  s_       | s_valid, s_ready, s_data   | in        | one process model per request
//  m_       | m_valid, m_ready, m_data   | out       | one tuning result per request
//
// One request is taken every clock cycle while the queue has room; the depth of
// the pipeline is dominated by the four chained passes of 33-stage dividers
// (ratio, shaping and time terms, proportional gain, integral gain).
// Reset is synchronous and active low and empties the queue and the pipeline.
// A stalled result holds the whole back end; the four-entry queue keeps
// s_ready high until it fills.

module cohen_coon_pid_tuner import cctun_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic s_valid,
    output logic s_ready,
    input  in_t  s_data,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    logic   q_full;
    logic   q_push;
    logic   q_pop;
    logic   q_not_empty;
    qitem_t q_push_item;
    qitem_t q_head_item;

    // The front end rejects nothing: invalid models travel on and come out
    // as an all-zero result, so every request gives exactly one result.
    cctun_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_full  (q_full),
        .q_push  (q_push),
        .q_item  (q_push_item)
    );

    // The queue decouples acceptance from the back end's stalls.
    cctun_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_push_item),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head_item (q_head_item)
    );

    // The back end advances whenever its output register is free or being read.
    cctun_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_not_empty),
        .q_item  (q_head_item),
        .q_pop   (q_pop),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

### src/cctun_checker.sv
// Port-level checks of the Cohen-Coon tuner, bound to the top level.
// Depends on cctun_pkg and cohen_coon_pid_tuner.
`default_nettype none

module cctun_checker import cctun_pkg::*; (
    input logic aclk,
    input logic aresetn,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data
);

    a_hold_result: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed or dropped while stalled");

    a_invalid_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.valid_res && !m_data.overflow |->
            m_data.prop_gain == 32'sd0 && m_data.settling_time == 32'sd0 &&
            m_data.delay_ratio == '0 && m_data.correction_class == CLS_UNITY)
        else $error("rejected model gave a non-zero result");

    a_valid_fields: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.valid_res |->
            m_data.expected_overshoot >= OS_FLOOR &&
            (m_data.correction_class == CLS_UNITY ||
             m_data.correction_class == CLS_LOW ||
             m_data.correction_class == CLS_HIGH))
        else $error("overshoot below floor or unknown correction class");

    a_ratio_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.valid_res && m_data.delay_ratio == RATIO_MAX |->
            m_data.overflow)
        else $error("saturated ratio without overflow flag");

    a_reset_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        $past(!aresetn) |-> !m_valid)
        else $error("result presented straight after reset");

endmodule

bind cohen_coon_pid_tuner cctun_checker u_cctun_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

### verif/tb_cohen_coon_pid_tuner.sv
// Testbench of cohen_coon_pid_tuner: directed and random process models, with
// the tuning results predicted in a small scoreboard and checked field by field.
// Depends on cctun_pkg and the RTL of the tuner; needs no files or arguments.
`timescale 1ns / 100ps

module tb_cohen_coon_pid_tuner;
    import cctun_pkg::*;

    // Scoreboard: works out the tuning result of each accepted request and
    // compares the results leaving the block with them, oldest first.
    class tuning_scoreboard;
        out_t tunings_due[$];
        int   faults;

        function new();
            faults = 0;
        endfunction

        static function longint clip32(longint v, ref bit ov);
            if (v > 64'sd2147483647) begin
                ov = 1'b1;
                return 64'sd2147483647;
            end
            if (v < -64'sd2147483648) begin
                ov = 1'b1;
                return -64'sd2147483648;
            end
            return v;
        endfunction

        // Cohen-Coon gains in 64-bit fixed point, truncating every product
        // and quotient towards zero as the block does.
        static function out_t tune(in_t x);
            longint k, t, l, r, cf, p, kp, half_r, tnum, tden, ti;
            longint dden, td, ki, kd, os, st;
            bit [63:0] ur, r2, den1, num1, f1;
            bit ov;
            logic [1:0] cls;
            out_t o;
            o = '0;
            ov = 1'b0;
            k = longint'(x.process_gain);
            t = longint'(x.time_constant);
            l = longint'(x.dead_time);
            if (t <= 0 || l < 0) return o;

            r = (l * ONE_L) / t;
            if (r > 64'sd2147483647) begin
                r = 64'sd2147483647;
                ov = 1'b1;
            end

            cls = CLS_UNITY;
            cf = ONE_L;
            if (r > longint'(C_06)) begin
                cls = CLS_LOW;
                cf = longint'(C_08);
            end else if (r < longint'(C_02)) begin
                cls = CLS_HIGH;
                cf = longint'(C_12);
            end

            ur = 64'(r);
            r2 = (ur * ur) >> FRAC_BITS;
            den1 = ONE + ((C_027 * r2) >> FRAC_BITS);
            num1 = (C_027 * ur) >> FRAC_BITS;
            f1 = ONE + (num1 << FRAC_BITS) / den1;
            p = longint'((C_135 * f1) >> FRAC_BITS);
            p = (p * cf) / ONE_L;
            if (k == 0) begin
                kp = 64'sd2147483647;
                ov = 1'b1;
            end else begin
                kp = clip32((p * ONE_L) / k, ov);
            end

            half_r = (longint'(C_05) * r) / ONE_L;
            tnum = longint'(C_25) - half_r;
            tden = ONE_L + half_r;
            ti = clip32((t * tnum) / tden, ov);

            dden = ONE_L + (longint'(C_02) * r) / ONE_L;
            td = clip32((t * longint'(C_037)) / dden, ov);

            if (ti == 0) begin
                ki = (kp >= 0) ? 64'sd2147483647 : -64'sd2147483648;
                ov = 1'b1;
            end else begin
                ki = clip32((kp * ONE_L) / ti, ov);
            end
            kd = clip32((kp * td) / ONE_L, ov);

            os = longint'(C_20) - (longint'(C_30) * r) / ONE_L;
            if (os < longint'(C_5)) os = longint'(C_5);
            st = clip32(3 * (l + t), ov);

            o.valid_res = (k != 0);
            o.overflow = ov;
            o.prop_gain = 32'(kp);
            o.integral_time = 32'(ti);
            o.derivative_time = 32'(td);
            o.integral_gain = 32'(ki);
            o.derivative_gain = 32'(kd);
            o.expected_overshoot = 32'(os);
            o.settling_time = 32'(st);
            o.delay_ratio = 31'(r);
            o.correction_class = cls;
            return o;
        endfunction

        function void note_request(in_t x);
            tunings_due.push_back(tune(x));
        endfunction

        function void cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v) begin
                $error("%s: expected %h, got %h", name, exp_v, act_v);
                faults++;
            end
        endfunction

        function void check_result(out_t got);
            out_t e;
            if (tunings_due.size() == 0) begin
                $error("result with no request outstanding: %h", got);
                faults++;
                return;
            end
            e = tunings_due.pop_front();
            cmp("valid_res", 32'(e.valid_res), 32'(got.valid_res));
            cmp("overflow", 32'(e.overflow), 32'(got.overflow));
            cmp("prop_gain", e.prop_gain, got.prop_gain);
            cmp("integral_time", e.integral_time, got.integral_time);
            cmp("derivative_time", e.derivative_time, got.derivative_time);
            cmp("integral_gain", e.integral_gain, got.integral_gain);
            cmp("derivative_gain", e.derivative_gain, got.derivative_gain);
            cmp("expected_overshoot", e.expected_overshoot, got.expected_overshoot);
            cmp("settling_time", e.settling_time, got.settling_time);
            cmp("delay_ratio", 32'(e.delay_ratio), 32'(got.delay_ratio));
            cmp("correction_class", 32'(e.correction_class), 32'(got.correction_class));
        endfunction
    endclass

    logic aclk;
    logic aresetn;
    logic s_valid;
    logic s_ready;
    in_t  s_data;
    logic m_valid;
    logic m_ready;
    out_t m_data;

    tuning_scoreboard sb;
    bit calm;   // while set, neither side idles

    cohen_coon_pid_tuner u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial aclk = 1'b0;
    always #6 aclk = ~aclk;

    // Result side: every accepted result is checked, and the ready line is
    // dropped about a quarter of the time unless a calm stretch is running.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) sb.check_result(m_data);
        m_ready <= calm ? 1'b1 : ($urandom_range(99) >= 24);
    end

    // Offers one request and notes it once the block has taken it. Valid is
    // only lowered for idle cycles, never between back-to-back requests.
    task automatic send_model(in_t x);
        while (!calm && $urandom_range(99) < 24) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= x;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(x);
    endtask

    task automatic send_tkl(logic [31:0] k, logic [31:0] t, logic [31:0] l);
        in_t x;
        x.process_gain = k;
        x.time_constant = t;
        x.dead_time = l;
        send_model(x);
    endtask

    // Random value of random magnitude, so that small and huge numbers both
    // turn up often.
    function automatic logic [31:0] spread_val();
        return $urandom >> $urandom_range(0, 31);
    endfunction

    task automatic send_random_model();
        logic [31:0] k, t, l;
        int pick;
        pick = $urandom_range(99);
        k = spread_val();
        if ($urandom_range(1)) k = -k;
        if (pick < 70) begin
            // Well-formed model, ratios mostly around the thresholds.
            t = spread_val() | 32'h1;
            t[31] = 1'b0;
            if ($urandom_range(1)) l = (t >> $urandom_range(0, 4)) + $urandom_range(0, 1000);
            else l = spread_val();
            l[31] = 1'b0;
        end else if (pick < 80) begin
            t = 32'(ONE_L);
            l = $urandom_range(0, 8 * 65536);
        end else begin
            // Raw noise, mostly invalid models.
            k = $urandom;
            t = $urandom;
            l = $urandom;
        end
        if ($urandom_range(49) == 0) k = '0;
        send_tkl(k, t, l);
    endtask

    // The last request has been taken, so valid drops while the results drain.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.tunings_due.size() != 0) @(posedge aclk);
    endtask

    initial begin
        sb = new();
        calm = 1'b0;
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        m_ready = 1'b0;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed requests: field extremes, invalid models, zero gain, a
        // saturated ratio, both thresholds and the zero integral time.
        send_tkl(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_tkl(32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
        send_tkl(32'h0001_0000, 32'h0, 32'h0001_0000);
        send_tkl(32'h0001_0000, 32'h8000_0000, 32'h0001_0000);
        send_tkl(32'h0001_0000, 32'h0001_0000, 32'h8000_0000);
        send_tkl(32'h0001_0000, 32'h0001_0000, 32'hFFFF_FFFF);
        send_tkl(32'h0, 32'h0001_0000, 32'h0000_8000);
        send_tkl(32'h0, 32'h0000_0001, 32'h7FFF_FFFF);
        send_tkl(32'h0002_0000, 32'h0000_0001, 32'h7FFF_FFFF);
        send_tkl(32'hFFFF_FFFF, 32'h0000_0001, 32'h0001_0000);
        send_tkl(32'h0001_0000, 32'h0001_0000, 32'(C_06));
        send_tkl(32'h0001_0000, 32'h0001_0000, 32'(C_06) + 1);
        send_tkl(32'h0001_0000, 32'h0001_0000, 32'(C_02));
        send_tkl(32'h0001_0000, 32'h0001_0000, 32'(C_02) - 1);
        send_tkl(32'h0001_0000, 32'h0001_0000, 32'h0005_0000);
        send_tkl(32'hFFFF_0000, 32'h0001_0000, 32'h0005_0000);
        send_tkl(32'h0000_0001, 32'h0001_0000, 32'h0);
        send_tkl(32'h0000_0001, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_tkl(32'h8000_0000, 32'h0000_0001, 32'h0);
        send_tkl(32'h0003_8000, 32'h000A_0000, 32'h0004_0000);

        // The sender holds off until the pipeline has emptied.
        wait_drained();

        for (int n = 0; n < 700; n++) begin
            calm = (n >= 300 && n < 400);
            send_random_model();
            if (n == 450) wait_drained();
        end
        calm = 1'b0;
        s_valid <= 1'b0;

        wait_drained();
        repeat (200) @(posedge aclk);
        if (sb.faults == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
